// File: rtl/fspd_pkg.sv
// ----------------------------------------------------------------------------
// fspd_pkg
// Shared types, codes and helpers for the fret solenoid peak-hold driver.
// ----------------------------------------------------------------------------
package fspd_pkg;

    localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
    localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    localparam logic KIND_PWM   = 1'b0;
    localparam logic KIND_SERVO = 1'b1;

    localparam logic [7:0] SERVO_MAX = 8'd180;

    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_BASE_NOTE    = 3'd0,
        REG_FRETS_IN_USE = 3'd1,
        REG_ATTACK_DUTY  = 3'd2,
        REG_HOLD_DUTY    = 3'd3,
        REG_ATTACK_TICKS = 3'd4,
        REG_MAX_ON_TICKS = 3'd5,
        REG_SERVO_CENTER = 3'd6,
        REG_PLUCK_OFFSET = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_ON,
        OP_OFF,
        OP_TICK
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    open;
    } cmd_ctl_t;

    typedef struct packed {
        logic [6:0]  base_note;
        logic [4:0]  frets_in_use;
        logic [11:0] attack_duty;
        logic [11:0] hold_duty;
        logic [15:0] attack_ticks;
        logic [15:0] max_on_ticks;
        logic [7:0]  servo_center;
        logic [6:0]  pluck_offset;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fret;
        logic [11:0] duty;
        logic [7:0]  servo_angle;
        logic        last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ON_PLUCK,
        ST_OFF_PWM,
        ST_SCAN,
        ST_FLUSH
    } back_state_t;

    // v is a signed 10-bit angle
    function automatic logic [7:0] sat_angle(input logic [9:0] v);
        logic [7:0] a;
        if (v[9])
            a = 8'd0;
        else if (v[8:0] > {1'b0, SERVO_MAX})
            a = SERVO_MAX;
        else
            a = v[7:0];
        return a;
    endfunction

    function automatic res_t mk_pwm(input logic [3:0] f, input logic [11:0] d);
        res_t r;
        r.kind        = KIND_PWM;
        r.fret        = f;
        r.duty        = d;
        r.servo_angle = 8'd0;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_servo(input logic [7:0] a);
        res_t r;
        r.kind        = KIND_SERVO;
        r.fret        = 4'd0;
        r.duty        = 12'd0;
        r.servo_angle = a;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/fret_solenoid_peak_hold_driver_unit.sv
// ----------------------------------------------------------------------------
// fret_solenoid_peak_hold_driver_unit
// Flow: a request passes the command queue, the back end and a one-deep result hold
//   into the result queue; the back end waits while the result queue is full.
// The back end takes one command at a time. On a tick while playing it scans
//   min(frets_in_use, MAX_FRETS) frets, one fret a cycle while the result queue has
//   room, and visits a fret twice when it drops to hold and is forced off on one tick.
// Reset: asynchronous; queues empty, config to defaults, all frets off.
// ----------------------------------------------------------------------------
module fret_solenoid_peak_hold_driver_unit
    import fspd_pkg::*;
#(
    parameter int MAX_FRETS = 16,
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [15:0] wr_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [6:0]  note,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [3:0]  fret,
    output logic [11:0] duty,
    output logic [7:0]  servo_angle,
    output logic        last
);

    localparam int IW = (MAX_FRETS > 1) ? $clog2(MAX_FRETS) : 1;
    localparam int CMD_W = $bits(cmd_ctl_t) + IW;
    localparam int RES_W = $bits(res_t);

    cfg_t             cfg_reg;
    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_ctl_t         fr_ctl;
    logic [IW-1:0]    fr_idx;
    logic [CMD_W-1:0] cmd_rdata;
    logic             res_push, res_full;
    res_t             res_wdata;
    logic [RES_W-1:0] res_rdata;
    res_t             res_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_note    <= 7'd67;
            cfg_reg.frets_in_use <= 5'd12;
            cfg_reg.attack_duty  <= 12'd4095;
            cfg_reg.hold_duty    <= 12'd1638;
            cfg_reg.attack_ticks <= 16'd50;
            cfg_reg.max_on_ticks <= 16'd5000;
            cfg_reg.servo_center <= 8'd90;
            cfg_reg.pluck_offset <= 7'd20;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_BASE_NOTE:    cfg_reg.base_note    <= wr_data[6:0];
                REG_FRETS_IN_USE: cfg_reg.frets_in_use <= wr_data[4:0];
                REG_ATTACK_DUTY:  cfg_reg.attack_duty  <= wr_data[11:0];
                REG_HOLD_DUTY:    cfg_reg.hold_duty    <= wr_data[11:0];
                REG_ATTACK_TICKS: cfg_reg.attack_ticks <= wr_data;
                REG_MAX_ON_TICKS: cfg_reg.max_on_ticks <= wr_data;
                REG_SERVO_CENTER: cfg_reg.servo_center <= wr_data[7:0];
                REG_PLUCK_OFFSET: cfg_reg.pluck_offset <= wr_data[6:0];
                default:          cfg_reg.base_note    <= cfg_reg.base_note;
            endcase
        end
    end

    fspd_front #(
        .MAX_FRETS (MAX_FRETS)
    ) u_front (
        .push     (push),
        .full     (full),
        .action   (action),
        .note     (note),
        .cfg      (cfg_reg),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd_ctl  (fr_ctl),
        .cmd_idx  (fr_idx)
    );

    fspd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata ({fr_ctl, fr_idx}),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    fspd_back #(
        .MAX_FRETS  (MAX_FRETS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_empty (cmd_empty),
        .cmd_ctl   (cmd_ctl_t'(cmd_rdata[CMD_W-1:IW])),
        .cmd_idx   (cmd_rdata[IW-1:0]),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    fspd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_q       = res_t'(res_rdata);
    assign kind        = res_q.kind;
    assign fret        = res_q.fret;
    assign duty        = res_q.duty;
    assign servo_angle = res_q.servo_angle;
    assign last        = res_q.last;

endmodule

// File: rtl/fspd_fifo.sv
// ----------------------------------------------------------------------------
// fspd_fifo
// Small synchronous queue with full/empty flags.
// ----------------------------------------------------------------------------
module fspd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CNTW'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNTW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// File: rtl/fspd_front.sv
// ----------------------------------------------------------------------------
// fspd_front
// Accepts requests, maps notes to frets, drops out-of-range notes and
// unused actions, and queues commands for the back end.
// ----------------------------------------------------------------------------
module fspd_front
    import fspd_pkg::*;
#(
    parameter int MAX_FRETS = 16,
    localparam int IW = (MAX_FRETS > 1) ? $clog2(MAX_FRETS) : 1,
    localparam int NFW = $clog2(MAX_FRETS + 1)
) (
    input  logic           push,
    output logic           full,
    input  logic [1:0]     action,
    input  logic [6:0]     note,
    input  cfg_t           cfg,
    input  logic           cmd_full,
    output logic           cmd_push,
    output cmd_ctl_t       cmd_ctl,
    output logic [IW-1:0]  cmd_idx
);

    logic [NFW-1:0] nf;
    logic [7:0]     diff;
    logic           in_range;
    logic           accept;

    assign nf = (6'(cfg.frets_in_use) > 6'(MAX_FRETS)) ? NFW'(MAX_FRETS)
                                                       : NFW'(cfg.frets_in_use);
    assign diff     = {1'b0, note} - {1'b0, cfg.base_note};
    assign in_range = !diff[7] && (diff[6:0] <= 7'(nf));
    assign full     = cmd_full;
    assign accept   = push && !cmd_full;

    always_comb
    begin
        cmd_ctl.open = (diff[6:0] == 7'd0);
        cmd_idx      = IW'(diff[6:0] - 7'd1);
        cmd_ctl.op   = OP_TICK;
        cmd_push     = 1'b0;
        case (action)
            ACT_NOTE_ON:
            begin
                cmd_ctl.op = OP_ON;
                cmd_push   = accept && in_range;
            end
            ACT_NOTE_OFF:
            begin
                cmd_ctl.op = OP_OFF;
                cmd_push   = accept && in_range;
            end
            ACT_TICK:
            begin
                cmd_ctl.op = OP_TICK;
                cmd_push   = accept;
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/fspd_back.sv
// ----------------------------------------------------------------------------
// fspd_back
// Executes queued commands: fret state, tick scan and pluck servo. Results
// pass through a one-deep hold so the final one of a request gets last.
// ----------------------------------------------------------------------------
module fspd_back
    import fspd_pkg::*;
#(
    parameter int MAX_FRETS = 16,
    parameter int TIMER_BITS = 16,
    localparam int IW = (MAX_FRETS > 1) ? $clog2(MAX_FRETS) : 1,
    localparam int NFW = $clog2(MAX_FRETS + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  logic           cmd_empty,
    input  cmd_ctl_t       cmd_ctl,
    input  logic [IW-1:0]  cmd_idx,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output res_t           res_data
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    back_state_t           state_reg, state_next;
    logic                  playing_reg;
    logic                  pluck_a_reg;
    logic [MAX_FRETS-1:0]  active_reg, hold_reg;
    logic [TIMER_BITS-1:0] elapsed_reg [MAX_FRETS];
    logic [NFW-1:0]        cur_idx_reg;
    res_t                  pend_reg;
    logic                  pend_valid_reg;

    logic [NFW-1:0] nf;
    logic [IW-1:0]  sel;
    logic [CW-1:0]  e_sel;
    logic           hold_fire, off_fire, scan_adv, last_idx, go;
    logic [9:0]     pluck_sum, pluck_dif;
    res_t           pluck_res, emit_res;
    logic           emit, flush;
    logic           set_play, clr_play, tog_pluck, note_load, off_clr, hold_set;
    logic           tick_inc, idx_load, idx_adv;
    logic [NFW-1:0] idx_val;

    assign nf = (6'(cfg.frets_in_use) > 6'(MAX_FRETS)) ? NFW'(MAX_FRETS)
                                                       : NFW'(cfg.frets_in_use);
    assign sel       = cur_idx_reg[IW-1:0];
    assign e_sel     = CW'(elapsed_reg[sel]);
    assign hold_fire = active_reg[sel] && !hold_reg[sel] && (e_sel > CW'(cfg.attack_ticks));
    assign off_fire  = active_reg[sel] && (e_sel > CW'(cfg.max_on_ticks));
    assign scan_adv  = !(hold_fire && off_fire);
    assign last_idx  = (NFW'(cur_idx_reg + 1'b1) == nf);
    assign go        = !res_full;

    assign pluck_sum = {2'b00, cfg.servo_center} + {3'b000, cfg.pluck_offset};
    assign pluck_dif = {2'b00, cfg.servo_center} - {3'b000, cfg.pluck_offset};
    assign pluck_res = mk_servo(sat_angle(pluck_a_reg ? pluck_sum : pluck_dif));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && go)
                begin
                    case (cmd_ctl.op)
                        OP_ON:   state_next = cmd_ctl.open ? ST_FLUSH : ST_ON_PLUCK;
                        OP_OFF:  state_next = cmd_ctl.open ? ST_FLUSH : ST_OFF_PWM;
                        OP_TICK: state_next = (playing_reg && nf != '0) ? ST_SCAN : ST_FLUSH;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ON_PLUCK: if (go) state_next = ST_FLUSH;
            ST_OFF_PWM:  if (go) state_next = ST_FLUSH;
            ST_SCAN:     if (go && scan_adv && last_idx) state_next = ST_FLUSH;
            ST_FLUSH:    if (go) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs / datapath strobes
    always_comb
    begin
        cmd_pop   = 1'b0;
        emit      = 1'b0;
        emit_res  = pluck_res;
        flush     = 1'b0;
        set_play  = 1'b0;
        clr_play  = 1'b0;
        tog_pluck = 1'b0;
        note_load = 1'b0;
        off_clr   = 1'b0;
        hold_set  = 1'b0;
        tick_inc  = 1'b0;
        idx_load  = 1'b0;
        idx_adv   = 1'b0;
        idx_val   = NFW'(cmd_idx);
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty && go)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_ctl.op)
                        OP_ON:
                        begin
                            set_play = 1'b1;
                            emit     = 1'b1;
                            if (cmd_ctl.open)
                                tog_pluck = 1'b1;
                            else
                            begin
                                emit_res  = mk_pwm(4'(cmd_idx), cfg.attack_duty);
                                note_load = 1'b1;
                                idx_load  = 1'b1;
                            end
                        end
                        OP_OFF:
                        begin
                            emit     = 1'b1;
                            emit_res = mk_servo(sat_angle({2'b00, cfg.servo_center}));
                            clr_play = 1'b1;
                            idx_load = 1'b1;
                        end
                        OP_TICK:
                        begin
                            tick_inc = 1'b1;
                            idx_load = 1'b1;
                            idx_val  = '0;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ON_PLUCK:
            begin
                if (go)
                begin
                    emit      = 1'b1;
                    tog_pluck = 1'b1;
                end
            end
            ST_OFF_PWM:
            begin
                if (go)
                begin
                    emit     = 1'b1;
                    emit_res = mk_pwm(4'(sel), 12'd0);
                    off_clr  = 1'b1;
                    clr_play = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    idx_adv = scan_adv;
                    if (hold_fire)
                    begin
                        emit     = 1'b1;
                        emit_res = mk_pwm(4'(sel), cfg.hold_duty);
                        hold_set = 1'b1;
                    end
                    else if (off_fire)
                    begin
                        emit     = 1'b1;
                        emit_res = mk_pwm(4'(sel), 12'd0);
                        off_clr  = 1'b1;
                        clr_play = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                flush = go;
            end
            default:
            begin
                flush = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_data      = pend_reg;
        res_data.last = flush;
        res_push      = (emit || flush) && pend_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            playing_reg    <= 1'b0;
            pluck_a_reg    <= 1'b1;
            active_reg     <= '0;
            hold_reg       <= '0;
            cur_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_FRETS; i++)
                elapsed_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_play)
                playing_reg <= 1'b1;
            else if (clr_play)
                playing_reg <= 1'b0;
            if (tog_pluck)
                pluck_a_reg <= !pluck_a_reg;
            if (idx_load)
                cur_idx_reg <= idx_val;
            else if (idx_adv)
                cur_idx_reg <= NFW'(cur_idx_reg + 1'b1);
            if (note_load)
            begin
                active_reg[cmd_idx]  <= 1'b1;
                hold_reg[cmd_idx]    <= 1'b0;
                elapsed_reg[cmd_idx] <= '0;
            end
            if (off_clr)
            begin
                active_reg[sel] <= 1'b0;
                hold_reg[sel]   <= 1'b0;
            end
            if (hold_set)
                hold_reg[sel] <= 1'b1;
            if (tick_inc)
            begin
                for (int i = 0; i < MAX_FRETS; i++)
                    if (active_reg[i] && elapsed_reg[i] != TMAX)
                        elapsed_reg[i] <= TIMER_BITS'(elapsed_reg[i] + 1'b1);
            end
            if (emit)
                pend_valid_reg <= 1'b1;
            else if (flush)
                pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            pend_reg <= emit_res;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_full |-> !res_push)
        else $error("result pushed into full queue");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind at idle");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cur_idx_reg < nf))
        else $error("scan index beyond frets in use");

    a_hold_active: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(hold_reg & ~active_reg) == 0)
        else $error("fret in hold but not active");

endmodule

// File: dv/tb_fret_solenoid_peak_hold_driver_unit.sv
// ----------------------------------------------------------------------------
// tb_fret_solenoid_peak_hold_driver_unit
// Self-checking bench for the fret solenoid peak-hold driver. A clocked driver
// feeds note on, note off and tick requests from a queue. A clocked monitor
// predicts the PWM and servo writes of each accepted request and compares each
// popped write field by field. Register settings change between phases while
// the block is idle. Phases cover directed corners, random traffic with random
// gaps and stalls, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_fret_solenoid_peak_hold_driver_unit;
    import fspd_pkg::*;

    localparam int NFRETS = 16;
    localparam logic [15:0] TIMER_TOP = 16'hFFFF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [1:0] action;
        logic [6:0] note;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [2:0]  wr_index = 3'd0;
    logic [15:0] wr_data = 16'd0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = 2'd0;
    logic [6:0]  note = 7'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic        kind;
    logic [3:0]  fret;
    logic [11:0] duty;
    logic [7:0]  servo_angle;
    logic        last;

    // predicted string state
    cfg_t        cfg;
    bit          playing;
    bit          pluck_up;
    bit          sol_on[NFRETS];
    bit          sol_hold[NFRETS];
    logic [15:0] sol_ticks[NFRETS];

    req_t pending_reqs[$];
    res_t writes_due[$];

    int  reqs_queued = 0;
    int  reqs_taken = 0;
    int  writes_seen = 0;
    int  errors = 0;
    int  idle_cycles = 0;
    int  settings_used = 1;
    bit  req_taken = 1'b0;
    bit  res_taken = 1'b0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  holdoff_req = 0;
    int  holdoff_ack = 0;
    int  holdoff_left = 0;

    fret_solenoid_peak_hold_driver_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .push        (push),
        .full        (full),
        .action      (action),
        .note        (note),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .fret        (fret),
        .duty        (duty),
        .servo_angle (servo_angle),
        .last        (last)
    );

    always #4 clk = ~clk;

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic res_t pwm_write(logic [3:0] f, logic [11:0] d);
        res_t r;
        r = '0;
        r.kind = KIND_PWM;
        r.fret = f;
        r.duty = d;
        return r;
    endfunction

    function automatic res_t servo_write(int angle);
        res_t r;
        r = '0;
        if (angle < 0)
            angle = 0;
        if (angle > 180)
            angle = 180;
        r.kind = KIND_SERVO;
        r.servo_angle = 8'(angle);
        return r;
    endfunction

    task automatic string_reset;
        cfg.base_note    = 7'd67;
        cfg.frets_in_use = 5'd12;
        cfg.attack_duty  = 12'd4095;
        cfg.hold_duty    = 12'd1638;
        cfg.attack_ticks = 16'd50;
        cfg.max_on_ticks = 16'd5000;
        cfg.servo_center = 8'd90;
        cfg.pluck_offset = 7'd20;
        playing  = 1'b0;
        pluck_up = 1'b1;
        for (int i = 0; i < NFRETS; i++)
        begin
            sol_on[i]    = 1'b0;
            sol_hold[i]  = 1'b0;
            sol_ticks[i] = 16'd0;
        end
    endtask

    // writes caused by one request, appended to writes_due
    task automatic string_step(req_t rq);
        res_t out[$];
        int   nf;
        int   f;
        int   c;
        int   o;
        bit   scan;
        nf = (cfg.frets_in_use > NFRETS) ? NFRETS : int'(cfg.frets_in_use);
        c = int'(cfg.servo_center);
        o = int'(cfg.pluck_offset);
        case (rq.action)
            ACT_TICK:
            begin
                scan = playing;
                for (int i = 0; i < NFRETS; i++)
                begin
                    if (sol_on[i] && sol_ticks[i] != TIMER_TOP)
                        sol_ticks[i] = sol_ticks[i] + 16'd1;
                end
                if (scan)
                begin
                    for (int i = 0; i < nf; i++)
                    begin
                        if (sol_on[i])
                        begin
                            if (!sol_hold[i] && sol_ticks[i] > cfg.attack_ticks)
                            begin
                                out.push_back(pwm_write(4'(i), cfg.hold_duty));
                                sol_hold[i] = 1'b1;
                            end
                            if (sol_ticks[i] > cfg.max_on_ticks)
                            begin
                                out.push_back(pwm_write(4'(i), 12'd0));
                                sol_on[i]   = 1'b0;
                                sol_hold[i] = 1'b0;
                                playing     = 1'b0;
                            end
                        end
                    end
                end
            end
            ACT_NOTE_ON, ACT_NOTE_OFF:
            begin
                f = int'(rq.note) - int'(cfg.base_note);
                if (f >= 0 && f <= nf)
                begin
                    if (rq.action == ACT_NOTE_ON)
                    begin
                        if (f != 0)
                        begin
                            out.push_back(pwm_write(4'(f - 1), cfg.attack_duty));
                            sol_on[f - 1]    = 1'b1;
                            sol_hold[f - 1]  = 1'b0;
                            sol_ticks[f - 1] = 16'd0;
                        end
                        playing = 1'b1;
                        out.push_back(servo_write(pluck_up ? c + o : c - o));
                        pluck_up = !pluck_up;
                    end
                    else
                    begin
                        out.push_back(servo_write(c));
                        if (f != 0)
                        begin
                            out.push_back(pwm_write(4'(f - 1), 12'd0));
                            sol_on[f - 1]   = 1'b0;
                            sol_hold[f - 1] = 1'b0;
                        end
                        playing = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (out.size() > 0)
            out[out.size() - 1].last = 1'b1;
        foreach (out[k])
            writes_due.push_back(out[k]);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        req_t rq;
        if (rst_n && (!push || req_taken))
        begin
            if (req_taken)
                send_gap = draw_wait(send_idle);
            if (send_gap > 0)
            begin
                push <= 1'b0;
                send_gap--;
            end
            else if (pending_reqs.size() > 0)
            begin
                rq = pending_reqs.pop_front();
                push   <= 1'b1;
                action <= rq.action;
                note   <= rq.note;
            end
            else
                push <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_req != holdoff_ack)
            begin
                holdoff_ack  = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (res_taken)
                recv_gap = draw_wait(recv_idle);
            if (holdoff_left > 0)
            begin
                pop <= 1'b0;
                holdoff_left--;
            end
            else if (pop && !res_taken)
                pop <= 1'b1;
            else if (recv_gap > 0)
            begin
                pop <= 1'b0;
                recv_gap--;
            end
            else
                pop <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n)
        begin
            req_taken <= push && !full;
            res_taken <= pop && !empty;
            if (push && !full)
            begin
                string_step(req_t'{action, note});
                reqs_taken++;
            end
            if (pop && !empty)
            begin
                got = '{kind, fret, duty, servo_angle, last};
                writes_seen++;
                if (writes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected write: expected none, actual %h", $time, got);
                end
                else
                begin
                    want = writes_due.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("fret", want.fret, got.fret);
                    check_field("duty", want.duty, got.duty);
                    check_field("servo_angle", want.servo_angle, got.servo_angle);
                    check_field("last", want.last, got.last);
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send(logic [1:0] a, logic [6:0] n);
        pending_reqs.push_back(req_t'{a, n});
        reqs_queued++;
    endtask

    task automatic cfg_write(reg_index_t idx, logic [15:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_BASE_NOTE:    cfg.base_note    = data[6:0];
            REG_FRETS_IN_USE: cfg.frets_in_use = data[4:0];
            REG_ATTACK_DUTY:  cfg.attack_duty  = data[11:0];
            REG_HOLD_DUTY:    cfg.hold_duty    = data[11:0];
            REG_ATTACK_TICKS: cfg.attack_ticks = data;
            REG_MAX_ON_TICKS: cfg.max_on_ticks = data;
            REG_SERVO_CENTER: cfg.servo_center = data[7:0];
            REG_PLUCK_OFFSET: cfg.pluck_offset = data[6:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic cfg_done;
        @(negedge clk);
        wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_drain;
        while (!(reqs_taken == reqs_queued && writes_due.size() == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(int style);
        logic [15:0] v[8];
        case (style)
            1:
            begin
                v[0] = 16'd0;     v[1] = 16'd16;  v[2] = 16'd0;   v[3] = 16'd4095;
                v[4] = 16'd0;     v[5] = 16'd0;   v[6] = 16'd0;   v[7] = 16'd127;
            end
            2:
            begin
                v[0] = 16'd111;   v[1] = 16'd31;  v[2] = 16'd4095; v[3] = 16'd0;
                v[4] = 16'hFFFF;  v[5] = 16'hFFFF; v[6] = 16'd255; v[7] = 16'd127;
            end
            3:
            begin
                v[0] = 16'($urandom_range(0, 127));
                v[1] = 16'($urandom_range(0, 31));
                v[2] = 16'($urandom_range(0, 4095));
                v[3] = 16'($urandom_range(0, 4095));
                v[4] = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 10));
                v[5] = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 30));
                v[6] = 16'($urandom_range(0, 255));
                v[7] = 16'($urandom_range(0, 127));
            end
            default:
            begin
                v[0] = 16'($urandom_range(40, 100));
                v[1] = (style == 4) ? 16'd0 : 16'($urandom_range(1, 16));
                v[2] = 16'($urandom_range(0, 4095));
                v[3] = 16'($urandom_range(0, 4095));
                v[4] = 16'($urandom_range(0, 6));
                v[5] = 16'($urandom_range(2, 30));
                v[6] = 16'($urandom_range(0, 180));
                v[7] = 16'($urandom_range(0, 90));
            end
        endcase
        for (int r = 0; r < 8; r++)
            cfg_write(reg_index_t'(r), v[r]);
        cfg_done();
    endtask

    // mostly in-range note traffic and ticks, with some stray notes and unused actions
    task automatic random_reqs(int count);
        int r;
        int nf;
        int n;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            nf = (cfg.frets_in_use > NFRETS) ? NFRETS : int'(cfg.frets_in_use);
            if (r < 40)
                send(ACT_TICK, 7'($urandom_range(0, 127)));
            else if (r < 88)
            begin
                n = int'(cfg.base_note) + int'($urandom_range(0, nf));
                if (n > 127)
                    n = $urandom_range(0, 127);
                send((r < 68) ? ACT_NOTE_ON : ACT_NOTE_OFF, 7'(n));
            end
            else if (r < 96)
                send($urandom_range(0, 1) ? ACT_NOTE_ON : ACT_NOTE_OFF,
                     7'($urandom_range(0, 127)));
            else
                send(ACT_UNUSED, 7'($urandom_range(0, 127)));
        end
    endtask

    initial
    begin
        int styles[7]  = '{0, 0, 1, 2, 3, 4, 3};
        int counts[7]  = '{40, 40, 35, 25, 40, 20, 40};
        bit s_idle[7]  = '{1, 0, 1, 1, 0, 1, 1};
        bit r_idle[7]  = '{1, 1, 1, 0, 0, 1, 1};
        bit holdoff[7] = '{0, 1, 0, 0, 0, 0, 0};

        string_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings: open string, frets, out of range, unused action
        send(ACT_NOTE_ON, 7'd67);
        send(ACT_NOTE_ON, 7'd68);
        send(ACT_NOTE_ON, 7'd79);
        send(ACT_NOTE_ON, 7'd80);
        send(ACT_NOTE_ON, 7'd66);
        send(ACT_TICK, 7'd127);
        send(ACT_NOTE_OFF, 7'd68);
        send(ACT_NOTE_OFF, 7'd67);
        send(ACT_UNUSED, 7'd127);
        send(ACT_NOTE_ON, 7'd0);
        send(ACT_TICK, 7'd0);
        send(ACT_NOTE_OFF, 7'd79);
        wait_drain();

        // short timers, angle saturation high, hold drop and forced off
        cfg_write(REG_BASE_NOTE, 16'd0);
        cfg_write(REG_FRETS_IN_USE, 16'd16);
        cfg_write(REG_ATTACK_DUTY, 16'd4095);
        cfg_write(REG_HOLD_DUTY, 16'd0);
        cfg_write(REG_ATTACK_TICKS, 16'd1);
        cfg_write(REG_MAX_ON_TICKS, 16'd3);
        cfg_write(REG_SERVO_CENTER, 16'd180);
        cfg_write(REG_PLUCK_OFFSET, 16'd90);
        cfg_done();
        send(ACT_NOTE_ON, 7'd1);
        send(ACT_NOTE_ON, 7'd16);
        send(ACT_NOTE_ON, 7'd17);
        repeat (5) send(ACT_TICK, 7'd0);
        send(ACT_NOTE_ON, 7'd0);
        send(ACT_NOTE_ON, 7'd0);
        send(ACT_NOTE_OFF, 7'd0);
        send(ACT_UNUSED, 7'd0);
        wait_drain();

        for (int p = 0; p < 7; p++)
        begin
            apply_settings(styles[p]);
            send_idle = s_idle[p];
            recv_idle = r_idle[p];
            if (holdoff[p])
                holdoff_req++;
            random_reqs(counts[p]);
            wait_drain();
        end

        $display("summary: %0d requests, %0d writes checked, %0d register settings",
                 reqs_taken, writes_seen, settings_used);
        $display("summary: notes in and out of range, hold drop, forced off, full stalls");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
